>>> rtl/lcpag_pkg.sv
// ============================================================================
// lcpag_pkg
// Shared types, constants and functions of the linked-cell C08 pair address
// generator: sweep state, limits, result item and the step rules.
// ============================================================================
package lcpag_pkg;

  // Largest cell count per axis, halo included.
  localparam int MAX_DIM     = 256;
  localparam int DIM_W       = 9;
  localparam int COORD_W     = 8;
  localparam int NUM_OFFSETS = 13;
  localparam int OFF_W       = 4;
  localparam int NUM_COLORS  = 8;
  localparam int COLOR_W     = 3;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;

  // Sweep phases; the fourth code never occurs and is treated as done.
  typedef enum logic [1:0] {
    PH_SINGLE = 2'd0,
    PH_PAIR   = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  // Configuration register indexes (byte address 4 * index).
  typedef enum logic [2:0] {
    REG_DIM_X     = 3'd0,
    REG_DIM_Y     = 3'd1,
    REG_DIM_Z     = 3'd2,
    REG_RUN_SINGLE = 3'd3,
    REG_RUN_PAIRS = 3'd4
  } reg_idx_t;

  typedef struct packed {
    phase_t             phase;
    logic [COLOR_W-1:0] color;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0] pos_z;
    logic [OFF_W-1:0]   offset_index;
  } sweep_state_t;

  // Loop limits (effective dim minus one) and phase enables.
  typedef struct packed {
    logic [COORD_W-1:0] lim_x;
    logic [COORD_W-1:0] lim_y;
    logic [COORD_W-1:0] lim_z;
    logic               run_single;
    logic               run_pairs;
  } sweep_cfg_t;

  typedef struct packed {
    logic               valid_res;
    logic               is_pair;
    logic [COORD_W-1:0] first_x;
    logic [COORD_W-1:0] first_y;
    logic [COORD_W-1:0] first_z;
    logic [COORD_W-1:0] second_x;
    logic [COORD_W-1:0] second_y;
    logic [COORD_W-1:0] second_z;
    logic               sweep_last;
  } result_t;

  // Clamp a dimension register to 3..MAX_DIM and return the loop limit.
  function automatic logic [COORD_W-1:0] dim_limit(logic [DIM_W-1:0] dim);
    logic [COORD_W-1:0] lim;
    if (dim < DIM_W'(3)) begin
      lim = COORD_W'(2);
    end else if (32'(dim) > MAX_DIM) begin
      lim = COORD_W'(MAX_DIM - 1);
    end else begin
      lim = COORD_W'(dim - DIM_W'(1));
    end
    return lim;
  endfunction

  // Offset pair per index: upper three bits first cell, lower three second;
  // bit 0 is +x, bit 1 is +y, bit 2 is +z.
  function automatic logic [5:0] pair_code(logic [OFF_W-1:0] idx);
    logic [5:0] code;
    case (idx)
      4'd0:    code = {3'd0, 3'd2};
      4'd1:    code = {3'd2, 3'd4};
      4'd2:    code = {3'd0, 3'd4};
      4'd3:    code = {3'd0, 3'd6};
      4'd4:    code = {3'd1, 3'd6};
      4'd5:    code = {3'd1, 3'd2};
      4'd6:    code = {3'd1, 3'd4};
      4'd7:    code = {3'd0, 3'd1};
      4'd8:    code = {3'd0, 3'd3};
      4'd9:    code = {3'd3, 3'd4};
      4'd10:   code = {3'd2, 3'd5};
      4'd11:   code = {3'd0, 3'd5};
      4'd12:   code = {3'd0, 3'd7};
      default: code = 6'd0;
    endcase
    return code;
  endfunction

  // State at the start of one color of the pair sweep.
  function automatic sweep_state_t color_start(sweep_state_t s,
                                               logic [COLOR_W-1:0] col);
    sweep_state_t r;
    r              = s;
    r.phase        = PH_PAIR;
    r.color        = col;
    r.pos_x        = COORD_W'(col[0]);
    r.pos_y        = COORD_W'(col[1]);
    r.pos_z        = COORD_W'(col[2]);
    r.offset_index = '0;
    return r;
  endfunction

  // Entry into the pair phase, or straight to done when it is disabled.
  function automatic sweep_state_t pair_start(sweep_state_t s, sweep_cfg_t c);
    sweep_state_t r;
    r = s;
    if (c.run_pairs) begin
      r = color_start(s, '0);
    end else begin
      r.phase = PH_DONE;
    end
    return r;
  endfunction

  // Move forward to the first legal position at or after the given one.
  // The nested loop wraps are resolved as a carry chain over x, y and z.
  function automatic sweep_state_t sweep_settle(sweep_state_t s, sweep_cfg_t c);
    sweep_state_t     r;
    logic [DIM_W-1:0] x, y, z, lx, ly, lz;
    logic [DIM_W-1:0] x1, y1, z1, x2, y2, z2;
    logic             xw, yw, zw, off_ovf;
    logic [OFF_W-1:0] off_n;
    r       = s;
    x       = {1'b0, s.pos_x};
    y       = {1'b0, s.pos_y};
    z       = {1'b0, s.pos_z};
    lx      = {1'b0, c.lim_x};
    ly      = {1'b0, c.lim_y};
    lz      = {1'b0, c.lim_z};
    x1      = x + DIM_W'(1);
    y1      = y + DIM_W'(1);
    z1      = z + DIM_W'(1);
    x2      = x + DIM_W'(2);
    y2      = y + DIM_W'(2);
    z2      = z + DIM_W'(2);
    off_ovf = (s.offset_index >= OFF_W'(NUM_OFFSETS));
    off_n   = off_ovf ? '0 : s.offset_index;
    xw      = 1'b0;
    yw      = 1'b0;
    zw      = 1'b0;
    case (s.phase)
      PH_SINGLE: begin
        xw = (x >= lx);
        yw = (y >= ly) || (xw && (y1 >= ly));
        zw = (z >= lz) || (yw && (z1 >= lz));
        if (!c.run_single || zw) begin
          r = pair_start(s, c);
        end else if (yw) begin
          r.pos_x = COORD_W'(1);
          r.pos_y = COORD_W'(1);
          r.pos_z = z1[COORD_W-1:0];
        end else if (xw) begin
          r.pos_x = COORD_W'(1);
          r.pos_y = y1[COORD_W-1:0];
        end
      end
      PH_PAIR: begin
        xw = (x >= lx) || (off_ovf && (x2 >= lx));
        yw = (y >= ly) || (xw && (y2 >= ly));
        zw = (z >= lz) || (yw && (z2 >= lz));
        if (!c.run_pairs) begin
          r.phase = PH_DONE;
        end else if (zw) begin
          if (s.color == COLOR_W'(NUM_COLORS - 1)) begin
            r.phase = PH_DONE;
          end else begin
            r = color_start(s, s.color + COLOR_W'(1));
          end
        end else if (yw) begin
          r.pos_x        = COORD_W'(s.color[0]);
          r.pos_y        = COORD_W'(s.color[1]);
          r.pos_z        = z2[COORD_W-1:0];
          r.offset_index = off_n;
        end else if (xw) begin
          r.pos_x        = COORD_W'(s.color[0]);
          r.pos_y        = y2[COORD_W-1:0];
          r.offset_index = off_n;
        end else if (off_ovf) begin
          r.pos_x        = x2[COORD_W-1:0];
          r.offset_index = '0;
        end
      end
      default: begin
        r.phase = PH_DONE;
      end
    endcase
    return r;
  endfunction

endpackage

>>> rtl/lcpag_if.sv
// ============================================================================
// lcpag_if
// Valid/ready channel interfaces of the pair address generator: the tick
// channel in and the address channel out.
// ============================================================================
interface lcpag_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface lcpag_out_if;
  logic       valid;
  logic       ready;
  logic       valid_res;
  logic       is_pair;
  logic [7:0] first_x;
  logic [7:0] first_y;
  logic [7:0] first_z;
  logic [7:0] second_x;
  logic [7:0] second_y;
  logic [7:0] second_z;
  logic       sweep_last;

  modport source (
    output valid, output valid_res, output is_pair,
    output first_x, output first_y, output first_z,
    output second_x, output second_y, output second_z,
    output sweep_last, input ready
  );
  modport sink (
    input valid, input valid_res, input is_pair,
    input first_x, input first_y, input first_z,
    input second_x, input second_y, input second_z,
    input sweep_last, output ready
  );
endinterface

>>> rtl/lcpag_cfg.sv
// ============================================================================
// lcpag_cfg
// APB-style configuration registers: dimensions and phase enables, with the
// clamped loop limits handed to the sweep logic.
// ============================================================================
module lcpag_cfg
  import lcpag_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output sweep_cfg_t        cfg
);

  logic [DIM_W-1:0] dim_x_r, dim_x_nxt;
  logic [DIM_W-1:0] dim_y_r, dim_y_nxt;
  logic [DIM_W-1:0] dim_z_r, dim_z_nxt;
  logic             run_single_r, run_single_nxt;
  logic             run_pairs_r, run_pairs_nxt;
  logic             wr_en;
  reg_idx_t         idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  // Write decode.
  always_comb begin
    dim_x_nxt      = dim_x_r;
    dim_y_nxt      = dim_y_r;
    dim_z_nxt      = dim_z_r;
    run_single_nxt = run_single_r;
    run_pairs_nxt  = run_pairs_r;
    if (wr_en) begin
      unique case (idx)
        REG_DIM_X:      dim_x_nxt      = pwdata[DIM_W-1:0];
        REG_DIM_Y:      dim_y_nxt      = pwdata[DIM_W-1:0];
        REG_DIM_Z:      dim_z_nxt      = pwdata[DIM_W-1:0];
        REG_RUN_SINGLE: run_single_nxt = pwdata[0];
        REG_RUN_PAIRS:  run_pairs_nxt  = pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_x_r      <= DIM_W'(3);
      dim_y_r      <= DIM_W'(3);
      dim_z_r      <= DIM_W'(3);
      run_single_r <= 1'b1;
      run_pairs_r  <= 1'b1;
    end else begin
      dim_x_r      <= dim_x_nxt;
      dim_y_r      <= dim_y_nxt;
      dim_z_r      <= dim_z_nxt;
      run_single_r <= run_single_nxt;
      run_pairs_r  <= run_pairs_nxt;
    end
  end

  // Read decode returns the raw register contents.
  always_comb begin
    unique case (idx)
      REG_DIM_X:      prdata = DATA_W'(dim_x_r);
      REG_DIM_Y:      prdata = DATA_W'(dim_y_r);
      REG_DIM_Z:      prdata = DATA_W'(dim_z_r);
      REG_RUN_SINGLE: prdata = DATA_W'(run_single_r);
      REG_RUN_PAIRS:  prdata = DATA_W'(run_pairs_r);
      default:        prdata = '0;
    endcase
  end

  // Effective loop limits.
  always_comb begin
    cfg.lim_x      = dim_limit(dim_x_r);
    cfg.lim_y      = dim_limit(dim_y_r);
    cfg.lim_z      = dim_limit(dim_z_r);
    cfg.run_single = run_single_r;
    cfg.run_pairs  = run_pairs_r;
  end

endmodule

>>> rtl/lcpag_sweep.sv
// ============================================================================
// lcpag_sweep
// Sweep position register and the single-pass step logic: settle, emit the
// address, advance, settle again to flag the final address.
// ============================================================================
module lcpag_sweep
  import lcpag_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  sweep_cfg_t cfg,
  input  logic       step,
  input  logic       restart,
  output result_t    res
);

  sweep_state_t state_r, state_nxt;
  sweep_state_t init_s, s0, s1, s2, s3;
  logic [5:0]   code;
  logic [2:0]   off_a, off_b;
  logic         active;

  // Start of the whole sweep.
  always_comb begin
    init_s              = '0;
    init_s.phase        = PH_SINGLE;
    init_s.pos_x        = COORD_W'(1);
    init_s.pos_y        = COORD_W'(1);
    init_s.pos_z        = COORD_W'(1);
  end

  // One tick: pick up a legal position, emit it, step, and look ahead.
  always_comb begin
    s0     = restart ? init_s : state_r;
    s1     = sweep_settle(s0, cfg);
    active = (s1.phase == PH_SINGLE) || (s1.phase == PH_PAIR);
    code   = (s1.phase == PH_PAIR) ? pair_code(s1.offset_index) : 6'd0;
    off_a  = code[5:3];
    off_b  = code[2:0];
    s2     = s1;
    if (s1.phase == PH_SINGLE) begin
      s2.pos_x = s1.pos_x + COORD_W'(1);
    end else if (s1.phase == PH_PAIR) begin
      s2.offset_index = s1.offset_index + OFF_W'(1);
    end
    s3 = sweep_settle(s2, cfg);
  end

  // Result fields; a finished sweep gives an all-zero item.
  always_comb begin
    res = '0;
    if (active) begin
      res.valid_res  = 1'b1;
      res.is_pair    = (s1.phase == PH_PAIR);
      res.first_x    = s1.pos_x + COORD_W'(off_a[0]);
      res.first_y    = s1.pos_y + COORD_W'(off_a[1]);
      res.first_z    = s1.pos_z + COORD_W'(off_a[2]);
      res.second_x   = s1.pos_x + COORD_W'(off_b[0]);
      res.second_y   = s1.pos_y + COORD_W'(off_b[1]);
      res.second_z   = s1.pos_z + COORD_W'(off_b[2]);
      res.sweep_last = (s3.phase != PH_SINGLE) && (s3.phase != PH_PAIR);
    end
  end

  assign state_nxt = step ? s3 : state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= init_s;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/lcpag_out_reg.sv
// ============================================================================
// lcpag_out_reg
// Result register between the step logic and the address channel. It takes
// a new item whenever it is empty or being drained in the same cycle.
// ============================================================================
module lcpag_out_reg
  import lcpag_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t d,
  input  logic    out_ready,
  output logic    out_valid,
  output result_t q,
  output logic    in_ready
);

  logic    valid_r, valid_nxt;
  result_t data_r, data_nxt;

  assign in_ready = !valid_r || out_ready;

  // Occupancy and payload update.
  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = d;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign q         = data_r;

endmodule

>>> rtl/linked_cell_c08_pair_address_generator.sv
// ============================================================================
// linked_cell_c08_pair_address_generator
// Address generator for a linked-cell force sweep: inner single cells, then
// the C08 cell-pair sweep over eight colors and thirteen offset pairs.
// ============================================================================
// Usage:
//   Each transaction on in_chan is one tick; restart = 1 begins the sweep
//   again, restart = 0 advances. Every tick yields exactly one transaction on
//   out_chan: a cell (is_pair = 0), a cell pair (is_pair = 1), or, once the
//   sweep is finished, an all-zero item with valid_res = 0. sweep_last marks
//   the final address of the sweep.
//   A tick is held in the output register and shown on out_chan in the cycle
//   after its acceptance. Throughput is one tick per cycle while out_chan.ready
//   is high, set by the single output register; the step logic is combinational.
//   The APB port holds the dimensions and phase enables; write it only while
//   no results are pending.
//   Reset clears the output register and puts the sweep at its first inner
//   cell; configuration returns to 3x3x3 with both phases enabled.
//   When the receiver stalls, the result register holds its item and
//   in_chan.ready drops until the item is taken.
// ============================================================================
module linked_cell_c08_pair_address_generator
  import lcpag_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  lcpag_in_if.sink          in_chan,
  lcpag_out_if.source       out_chan,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  sweep_cfg_t cfg;
  result_t    step_res;
  result_t    out_res;
  logic       in_ready;
  logic       accept;

  assign accept        = in_chan.valid && in_ready;
  assign in_chan.ready = in_ready;

  lcpag_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lcpag_sweep u_sweep (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .step    (accept),
    .restart (in_chan.restart),
    .res     (step_res)
  );

  lcpag_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .d         (step_res),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .q         (out_res),
    .in_ready  (in_ready)
  );

  // Result fields onto the channel.
  assign out_chan.valid_res  = out_res.valid_res;
  assign out_chan.is_pair    = out_res.is_pair;
  assign out_chan.first_x    = out_res.first_x;
  assign out_chan.first_y    = out_res.first_y;
  assign out_chan.first_z    = out_res.first_z;
  assign out_chan.second_x   = out_res.second_x;
  assign out_chan.second_y   = out_res.second_y;
  assign out_chan.second_z   = out_res.second_z;
  assign out_chan.sweep_last = out_res.sweep_last;

endmodule

>>> rtl/lcpag_checker.sv
// ============================================================================
// lcpag_checker
// Port-level checks of the pair address generator, bound to the top level.
// ============================================================================
module lcpag_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       valid_res,
  input logic       is_pair,
  input logic [7:0] first_x,
  input logic [7:0] first_y,
  input logic [7:0] first_z,
  input logic [7:0] second_x,
  input logic [7:0] second_y,
  input logic [7:0] second_z,
  input logic       sweep_last
);

  // A stalled result stays put until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({valid_res, is_pair, first_x, first_y, first_z,
               second_x, second_y, second_z, sweep_last}))
    else $error("stalled result changed");

  // An empty result register always takes the next tick.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while result register empty");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // A finished sweep reports an all-zero item.
  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !valid_res |->
      !is_pair && !sweep_last && (first_x == 8'd0) && (first_y == 8'd0) &&
      (first_z == 8'd0) && (second_x == 8'd0) && (second_y == 8'd0) &&
      (second_z == 8'd0))
    else $error("done item carries nonzero fields");

  // A single cell names the same cell twice.
  a_single_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && valid_res && !is_pair |->
      (second_x == first_x) && (second_y == first_y) && (second_z == first_z))
    else $error("single cell with differing second cell");

endmodule

bind linked_cell_c08_pair_address_generator lcpag_checker u_lcpag_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .valid_res  (out_chan.valid_res),
  .is_pair    (out_chan.is_pair),
  .first_x    (out_chan.first_x),
  .first_y    (out_chan.first_y),
  .first_z    (out_chan.first_z),
  .second_x   (out_chan.second_x),
  .second_y   (out_chan.second_y),
  .second_z   (out_chan.second_z),
  .sweep_last (out_chan.sweep_last)
);

>>> tb/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for the linked-cell C08 pair address generator. Ticks
// go in on the input channel and addresses come out on the result channel.
// A scoreboard carries its own copy of the sweep state and the registers, and
// it compares every address transaction with the oldest expected address.
// ============================================================================
module testbench;
  import lcpag_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_WAIT  = 4;

  // Offset pairs in sweep order, one byte each, entry 0 in the low byte.
  // Bits 6:4 give the first cell and bits 2:0 the second cell.
  // Bit 0 of each is +x, bit 1 is +y and bit 2 is +z.
  localparam bit [NUM_OFFSETS*8-1:0] NEIGHBOR_CODES = {
    8'h07, 8'h05, 8'h25, 8'h34, 8'h03, 8'h01, 8'h14,
    8'h12, 8'h16, 8'h06, 8'h04, 8'h24, 8'h02
  };

  // Scoreboard: it tracks the sweep and holds the addresses still owed.
  class c08_sweep_scoreboard;
    bit [DIM_W-1:0] dim_reg [3];
    bit             single_en;
    bit             pair_en;
    phase_t         phase;
    int unsigned    color;
    int unsigned    px, py, pz;
    int unsigned    off_idx;
    result_t        pending_addrs [$];
    int             mismatches;

    function new();
      dim_reg    = '{DIM_W'(3), DIM_W'(3), DIM_W'(3)};
      single_en  = 1'b1;
      pair_en    = 1'b1;
      mismatches = 0;
      restart_sweep();
    endfunction

    function void restart_sweep();
      phase   = PH_SINGLE;
      color   = 0;
      px      = 1;
      py      = 1;
      pz      = 1;
      off_idx = 0;
    endfunction

    function void set_register(reg_idx_t idx, int unsigned value);
      case (idx)
        REG_DIM_X:      dim_reg[0] = value[DIM_W-1:0];
        REG_DIM_Y:      dim_reg[1] = value[DIM_W-1:0];
        REG_DIM_Z:      dim_reg[2] = value[DIM_W-1:0];
        REG_RUN_SINGLE: single_en  = value[0];
        REG_RUN_PAIRS:  pair_en    = value[0];
        default: ;
      endcase
    endfunction

    // Loop limit of one axis: the dimension clamped to 3..MAX_DIM, minus one.
    function int unsigned axis_limit(bit [DIM_W-1:0] d);
      if (d < 3) return 2;
      if (d > MAX_DIM) return MAX_DIM - 1;
      return int'(d) - 1;
    endfunction

    function void start_color();
      px      = color & 1;
      py      = (color >> 1) & 1;
      pz      = (color >> 2) & 1;
      off_idx = 0;
    endfunction

    // Carry the position forward to the next legal one under the current limits.
    function void settle_position();
      int unsigned lx, ly, lz;
      lx = axis_limit(dim_reg[0]);
      ly = axis_limit(dim_reg[1]);
      lz = axis_limit(dim_reg[2]);
      forever begin
        if (phase == PH_SINGLE) begin
          if (!single_en || pz >= lz) begin
            phase = PH_PAIR;
            color = 0;
            start_color();
          end else if (py >= ly) begin
            py = 1;
            px = 1;
            pz++;
          end else if (px >= lx) begin
            px = 1;
            py++;
          end else begin
            return;
          end
        end else if (phase == PH_PAIR) begin
          if (!pair_en || color >= NUM_COLORS) begin
            phase = PH_DONE;
          end else if (pz >= lz) begin
            color++;
            if (color >= NUM_COLORS) phase = PH_DONE;
            else start_color();
          end else if (py >= ly) begin
            py = (color >> 1) & 1;
            px = color & 1;
            pz += 2;
          end else if (px >= lx) begin
            px = color & 1;
            py += 2;
          end else if (off_idx >= NUM_OFFSETS) begin
            off_idx = 0;
            px += 2;
          end else begin
            return;
          end
        end else begin
          return;
        end
      end
    endfunction

    // One accepted tick: work out the address that it must produce.
    function void note_tick(bit restart);
      result_t     r;
      bit [7:0]    code;
      bit [2:0]    a, b;
      int unsigned fx, fy, fz, sx, sy, sz;
      if (restart) restart_sweep();
      settle_position();
      r = '0;
      if (phase == PH_SINGLE) begin
        r.is_pair = 1'b0;
        fx = px;
        fy = py;
        fz = pz;
        sx = px;
        sy = py;
        sz = pz;
        px++;
      end else if (phase == PH_PAIR) begin
        code = NEIGHBOR_CODES[8*off_idx +: 8];
        a    = code[6:4];
        b    = code[2:0];
        r.is_pair = 1'b1;
        fx = px + a[0];
        fy = py + a[1];
        fz = pz + a[2];
        sx = px + b[0];
        sy = py + b[1];
        sz = pz + b[2];
        off_idx++;
      end else begin
        // Sweep finished: an all-zero item with valid_res low.
        pending_addrs.push_back(r);
        return;
      end
      settle_position();
      r.valid_res  = 1'b1;
      r.first_x    = fx[7:0];
      r.first_y    = fy[7:0];
      r.first_z    = fz[7:0];
      r.second_x   = sx[7:0];
      r.second_y   = sy[7:0];
      r.second_z   = sz[7:0];
      r.sweep_last = (phase == PH_DONE);
      pending_addrs.push_back(r);
    endfunction

    function void check_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
      if (act_val !== exp_val) begin
        $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
        mismatches++;
      end
    endfunction

    // One accepted address transaction against the oldest expected address.
    function void check_address(result_t got);
      result_t want;
      if (pending_addrs.size() == 0) begin
        $error("address transaction with no tick waiting for it");
        mismatches++;
        return;
      end
      want = pending_addrs.pop_front();
      check_field("valid_res", 8'(want.valid_res), 8'(got.valid_res));
      check_field("is_pair", 8'(want.is_pair), 8'(got.is_pair));
      check_field("first_x", want.first_x, got.first_x);
      check_field("first_y", want.first_y, got.first_y);
      check_field("first_z", want.first_z, got.first_z);
      check_field("second_x", want.second_x, got.second_x);
      check_field("second_y", want.second_y, got.second_y);
      check_field("second_z", want.second_z, got.second_z);
      check_field("sweep_last", 8'(want.sweep_last), 8'(got.sweep_last));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  lcpag_in_if  in_if ();
  lcpag_out_if out_if ();

  c08_sweep_scoreboard sb;
  int                  in_idle_pct;
  int                  out_idle_pct;
  int                  cycles = 0;

  linked_cell_c08_pair_address_generator DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Receiver stalls at random.
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  // Check every accepted address transaction.
  always @(posedge clk) begin
    result_t got;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got.valid_res  = out_if.valid_res;
      got.is_pair    = out_if.is_pair;
      got.first_x    = out_if.first_x;
      got.first_y    = out_if.first_y;
      got.first_z    = out_if.first_z;
      got.second_x   = out_if.second_x;
      got.second_y   = out_if.second_y;
      got.second_z   = out_if.second_z;
      got.sweep_last = out_if.sweep_last;
      sb.check_address(got);
    end
  end

  // One register write: setup cycle, then access cycle until pready.
  task automatic cfg_write(reg_idx_t idx, int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.set_register(idx, value);
  endtask

  // Wait until every owed address has come out, then let the block settle.
  task automatic wait_drained();
    while (sb.pending_addrs.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_settings(int unsigned dx, int unsigned dy, int unsigned dz,
                                bit run_single, bit run_pairs);
    wait_drained();
    cfg_write(REG_DIM_X, dx);
    cfg_write(REG_DIM_Y, dy);
    cfg_write(REG_DIM_Z, dz);
    cfg_write(REG_RUN_SINGLE, run_single);
    cfg_write(REG_RUN_PAIRS, run_pairs);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // One tick transaction, with random gaps ahead of it.
  task automatic send_tick(bit restart);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.restart <= restart;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    sb.note_tick(restart);
  endtask

  task automatic send_ticks(int n, bit first_restart);
    bit rs;
    for (int i = 0; i < n; i++) begin
      // Restarts are rare mid-sweep, and likely once the sweep has finished.
      if (i == 0 && first_restart) rs = 1'b1;
      else if (sb.phase == PH_DONE) rs = ($urandom_range(0, 3) == 0);
      else rs = ($urandom_range(0, 99) == 0);
      send_tick(rs);
    end
    in_if.valid <= 1'b0;
  endtask

  // Mostly small sizes, now and then an out-of-range value or the largest size.
  function automatic int unsigned pick_dim();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(0, 2);
    if (r == 1) return $urandom_range(MAX_DIM + 1, 511);
    if (r == 2) return MAX_DIM;
    return $urandom_range(3, 5);
  endfunction

  initial begin
    int unsigned dims [3];
    sb = new();
    in_if.valid   <= 1'b0;
    in_if.restart <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    rst_n         <= 1'b0;
    in_idle_pct   = 7;
    out_idle_pct  = 82;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, first cell, first pair, restart.
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    in_if.valid <= 1'b0;

    // Dimensions below the minimum act as 3; the pair phase is off, so the
    // single inner cell is the last address and the sweep then stays done.
    write_settings(0, 1, 2, 1'b1, 1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    in_if.valid <= 1'b0;

    // Both phases off: done at once.
    write_settings(3, 3, 3, 1'b0, 1'b0);
    send_tick(1'b1);
    in_if.valid <= 1'b0;

    // Pairs only: all thirteen offset pairs of the first base.
    write_settings(3, 3, 3, 1'b0, 1'b1);
    send_tick(1'b1);
    for (int i = 0; i < NUM_OFFSETS - 1; i++) send_tick(1'b0);
    in_if.valid <= 1'b0;

    // Sizes above the maximum, changed mid-sweep: the position carries on.
    write_settings(511, MAX_DIM + 1, 3, 1'b0, 1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    in_if.valid <= 1'b0;

    // Random part under three idling modes.
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          in_idle_pct  = 7;
          out_idle_pct = 82;
        end
        1: begin
          in_idle_pct  = 82;
          out_idle_pct = 7;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
      endcase
      for (int ph = 0; ph < 6; ph++) begin
        if (ph == 0) begin
          // One long axis at the largest size, walked from the start.
          dims       = '{3, 3, 3};
          dims[mode] = (mode == 1) ? 511 : MAX_DIM;
          write_settings(dims[0], dims[1], dims[2], 1'b1, 1'b1);
          send_ticks(260, 1'b1);
        end else begin
          write_settings(pick_dim(), pick_dim(), pick_dim(),
                         $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
          send_ticks($urandom_range(50, 90), 1'b0);
        end
      end
    end

    wait_drained();
    if (sb.mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
